// ===== src/ctp_pkg.sv =====
// Package for the combination tone planner: widths, codes and shared types.
// Used by ctp_ctrl, ctp_dp and combination_tone_planner.
package ctp_pkg;
    localparam int TONE_SLOTS = 6;
    localparam int SLOT_W     = 4;
    localparam int SIDX_W     = (TONE_SLOTS > 1) ? $clog2(TONE_SLOTS) : 1;
    localparam int QW         = 16;
    localparam int FW         = 20;
    localparam int CFG_IDX_W  = 2;
    localparam logic [QW-1:0] Q_ONE       = 16'd32768;
    localparam logic [FW-1:0] MIN_FREQ    = 20'd320;
    localparam logic [QW-1:0] DIFF_WEIGHT = 16'd22938;
    localparam logic [FW-1:0] UPPER_RESET = 20'd317520;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIX       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER     = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_RANK,
        ST_PAIR_P,
        ST_PAIR_S,
        ST_PAIR_M,
        ST_PAIR_D,
        ST_EMIT
    } ctp_state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic rank;
        logic mul_p;
        logic mul_s;
        logic mul_m;
        logic place;
        logic emit_next;
    } ctp_cmd_t;

    typedef struct packed {
        logic active;
        logic div_done;
        logic pair_last;
        logic emit_last;
    } ctp_sts_t;

    function automatic logic [QW-1:0] clamp_q(input logic [QW-1:0] v);
        return (v > Q_ONE) ? Q_ONE : v;
    endfunction
endpackage

// ===== src/ctp_ctrl.sv =====
// Controller for the combination tone planner: sequences divide, pair
// multiplies and the slot emit. Depends on ctp_pkg.
module ctp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic             out_free,
    input  ctp_pkg::ctp_sts_t sts,
    output ctp_pkg::ctp_cmd_t cmd,
    output logic             busy
);
    import ctp_pkg::*;

    ctp_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (sts.active)
                begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV;
                end
                else
                    state_next = ST_EMIT;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = ST_RANK;
            end
            ST_RANK:
            begin
                cmd.rank = 1'b1;
                state_next = ST_PAIR_P;
            end
            ST_PAIR_P:
            begin
                cmd.mul_p = 1'b1;
                state_next = ST_PAIR_S;
            end
            ST_PAIR_S:
            begin
                cmd.mul_s = 1'b1;
                state_next = ST_PAIR_M;
            end
            ST_PAIR_M:
            begin
                cmd.mul_m = 1'b1;
                state_next = ST_PAIR_D;
            end
            ST_PAIR_D:
            begin
                cmd.place = 1'b1;
                state_next = sts.pair_last ? ST_EMIT : ST_PAIR_P;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit_next = 1'b1;
                    if (sts.emit_last)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// ===== src/ctp_dp.sv =====
// Datapath for the combination tone planner: operand registers, shift-subtract
// divider, shared multiplier, slot store and output register. Depends on ctp_pkg.
module ctp_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ctp_pkg::ctp_cmd_t                 cmd,
    output ctp_pkg::ctp_sts_t                 sts,
    input  logic                              cfg_we,
    input  logic [ctp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ctp_pkg::FW-1:0]            cfg_data,
    input  logic [ctp_pkg::QW-1:0]            global_energy,
    input  logic [ctp_pkg::QW-1:0]            band0_energy,
    input  logic [ctp_pkg::QW-1:0]            band1_energy,
    input  logic [ctp_pkg::QW-1:0]            band2_energy,
    input  logic [ctp_pkg::QW-1:0]            band3_energy,
    input  logic [ctp_pkg::FW-1:0]            band0_freq,
    input  logic [ctp_pkg::FW-1:0]            band1_freq,
    input  logic [ctp_pkg::FW-1:0]            band2_freq,
    input  logic [ctp_pkg::FW-1:0]            band3_freq,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [ctp_pkg::SLOT_W-1:0]        slot_index,
    output logic [ctp_pkg::FW-1:0]            slot_freq,
    output logic [ctp_pkg::QW-1:0]            slot_gain,
    output logic                              last_slot
);
    import ctp_pkg::*;

    logic [QW-1:0] thr_reg, mix_reg;
    logic [FW-1:0] upper_reg;
    logic [QW-1:0] g_reg;
    logic [QW-1:0] e_reg [4];
    logic [FW-1:0] f_reg [4];
    logic [QW-1:0] te_reg [3];
    logic [FW-1:0] tf_reg [3];
    logic [FW-1:0] store_reg [TONE_SLOTS];
    logic [QW-1:0] gain_reg [TONE_SLOTS];
    logic [SIDX_W:0] filled_reg;
    logic [1:0] pair_reg;
    logic [16:0] scale_reg;
    // restoring divider: 31-bit dividend, 17-bit divisor
    logic [30:0] quo_reg;
    logic [17:0] rem_reg;
    logic [16:0] den_reg;
    logic [4:0]  dcnt_reg;
    logic        div_trivial_reg;
    logic [QW-1:0] mul_reg;
    logic [QW-1:0] gs_reg;
    logic [SIDX_W:0] emit_reg;
    logic [SLOT_W-1:0] oidx_reg;
    logic [FW-1:0] ofreq_reg;
    logic [QW-1:0] ogain_reg;
    logic olast_reg, ovalid_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= '0;
            mix_reg   <= Q_ONE;
            upper_reg <= UPPER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: thr_reg <= clamp_q(cfg_data[QW-1:0]);
                REG_MIX:       mix_reg <= clamp_q(cfg_data[QW-1:0]);
                REG_UPPER:     upper_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign sts.active = (g_reg >= thr_reg);

    // ranking of the four bands
    logic [1:0] rank_c [4];
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rank_c[i] = '0;
            for (int j = 0; j < 4; j++)
                if ((e_reg[j] > e_reg[i]) || ((e_reg[j] == e_reg[i]) && (j < i)))
                    rank_c[i] = rank_c[i] + 2'd1;
        end
    end

    // pair selection (0,1) (0,2) (1,2)
    logic [1:0] pa, pb;
    always_comb
    begin
        case (pair_reg)
            2'd0:    begin pa = 2'd0; pb = 2'd1; end
            2'd1:    begin pa = 2'd0; pb = 2'd2; end
            default: begin pa = 2'd1; pb = 2'd2; end
        endcase
    end
    assign sts.pair_last = (pair_reg == 2'd2);

    // shared multiplier
    logic [16:0] mul_a, mul_b;
    logic [33:0] mul_prod;
    always_comb
    begin
        mul_a = {1'b0, te_reg[pa]};
        mul_b = {1'b0, te_reg[pb]};
        if (cmd.mul_s)
        begin
            mul_a = {1'b0, mul_reg};
            mul_b = scale_reg;
        end
        else if (cmd.mul_m)
        begin
            mul_a = {1'b0, mul_reg};
            mul_b = {1'b0, mix_reg};
        end
        else if (cmd.place)
        begin
            mul_a = {1'b0, gs_reg};
            mul_b = {1'b0, DIFF_WEIGHT};
        end
        mul_prod = mul_a * mul_b;
    end

    logic [FW:0] sumf;
    logic [FW-1:0] difff;
    logic sum_ok, diff_ok;
    logic [SIDX_W:0] fill_after_sum;
    always_comb
    begin
        sumf  = {1'b0, tf_reg[pa]} + {1'b0, tf_reg[pb]};
        difff = (tf_reg[pa] > tf_reg[pb]) ? tf_reg[pa] - tf_reg[pb]
                                          : tf_reg[pb] - tf_reg[pa];
        sum_ok = (filled_reg < (SIDX_W+1)'(TONE_SLOTS)) && (sumf > {1'b0, MIN_FREQ})
                 && (sumf < {1'b0, upper_reg});
        fill_after_sum = sum_ok ? filled_reg + 1'b1 : filled_reg;
        diff_ok = (fill_after_sum < (SIDX_W+1)'(TONE_SLOTS)) && (difff > MIN_FREQ)
                  && (difff < upper_reg);
    end

    logic [17:0] rem_sh;
    logic [17:0] rem_sub;
    always_comb
    begin
        rem_sh  = {rem_reg[16:0], quo_reg[30]};
        rem_sub = rem_sh - {1'b0, den_reg};
    end
    assign sts.div_done = div_trivial_reg || (dcnt_reg == 5'd0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            g_reg <= clamp_q(global_energy);
            e_reg[0] <= clamp_q(band0_energy);
            e_reg[1] <= clamp_q(band1_energy);
            e_reg[2] <= clamp_q(band2_energy);
            e_reg[3] <= clamp_q(band3_energy);
            f_reg[0] <= band0_freq;
            f_reg[1] <= band1_freq;
            f_reg[2] <= band2_freq;
            f_reg[3] <= band3_freq;
            for (int k = 0; k < TONE_SLOTS; k++)
                gain_reg[k] <= '0;
            filled_reg <= '0;
            pair_reg <= '0;
        end
        if (cmd.div_start)
        begin
            div_trivial_reg <= (thr_reg >= Q_ONE);
            quo_reg  <= {g_reg - thr_reg, 15'd0};
            rem_reg  <= '0;
            den_reg  <= {1'b0, Q_ONE} - {1'b0, thr_reg};
            dcnt_reg <= 5'd31;
        end
        else if (cmd.div_step && !sts.div_done)
        begin
            if (!rem_sub[17])
            begin
                rem_reg <= rem_sub;
                quo_reg <= {quo_reg[29:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[29:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg - 5'd1;
        end
        if (cmd.rank)
        begin
            scale_reg <= div_trivial_reg ? {1'b0, Q_ONE}
                       : (quo_reg > 31'(Q_ONE)) ? {1'b0, Q_ONE} : quo_reg[16:0];
            for (int i = 0; i < 4; i++)
                if (rank_c[i] != 2'd3)
                begin
                    te_reg[rank_c[i]] <= e_reg[i];
                    tf_reg[rank_c[i]] <= f_reg[i];
                end
        end
        if (cmd.mul_p || cmd.mul_s)
            mul_reg <= mul_prod[30:15];
        if (cmd.mul_m)
            gs_reg <= mul_prod[30:15];
        if (cmd.place)
        begin
            if (sum_ok)
            begin
                gain_reg[filled_reg[SIDX_W-1:0]] <= gs_reg;
            end
            if (diff_ok)
            begin
                gain_reg[fill_after_sum[SIDX_W-1:0]] <= mul_prod[30:15];
            end
            filled_reg <= diff_ok ? fill_after_sum + 1'b1 : fill_after_sum;
            pair_reg <= pair_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int k = 0; k < TONE_SLOTS; k++)
                store_reg[k] <= '0;
        else if (cmd.place)
        begin
            if (sum_ok)
                store_reg[filled_reg[SIDX_W-1:0]] <= sumf[FW-1:0];
            if (diff_ok)
                store_reg[fill_after_sum[SIDX_W-1:0]] <= difff;
        end
    end

    // output register
    assign sts.emit_last = (emit_reg == (SIDX_W+1)'(TONE_SLOTS - 1));
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            emit_reg   <= '0;
        end
        else
        begin
            if (ovalid_reg && !out_stall)
                ovalid_reg <= 1'b0;
            if (cmd.emit_next)
            begin
                ovalid_reg <= 1'b1;
                emit_reg <= sts.emit_last ? '0 : emit_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_next)
        begin
            oidx_reg  <= SLOT_W'(emit_reg);
            ofreq_reg <= store_reg[emit_reg[SIDX_W-1:0]];
            ogain_reg <= gain_reg[emit_reg[SIDX_W-1:0]];
            olast_reg <= sts.emit_last;
        end
    end

    assign out_valid  = ovalid_reg;
    assign slot_index = oidx_reg;
    assign slot_freq  = ofreq_reg;
    assign slot_gain  = ogain_reg;
    assign last_slot  = olast_reg;
endmodule

// ===== src/combination_tone_planner.sv =====
// Top level of the combination tone planner: joins controller and datapath.
// Depends on ctp_pkg, ctp_ctrl and ctp_dp.
//
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | global_energy, band0..3_energy, band0..3_freq
//  out     | out_valid / out_stall| slot_index, slot_freq, slot_gain, last_slot
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// An active item is loaded, divided by the shift-subtract divider for the
// activation scale, ranked, then runs the product, scale, mix and place steps
// per band pair on the shared multiplier, then emits one slot per cycle, each
// slot waiting while the output register is stalled. A silenced item skips
// straight to the emit. The next item is taken once the last slot has entered
// the output register stage. Reset clears control and the slot frequency store.
module combination_tone_planner (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ctp_pkg::QW-1:0]        global_energy,
    input  logic [ctp_pkg::QW-1:0]        band0_energy,
    input  logic [ctp_pkg::QW-1:0]        band1_energy,
    input  logic [ctp_pkg::QW-1:0]        band2_energy,
    input  logic [ctp_pkg::QW-1:0]        band3_energy,
    input  logic [ctp_pkg::FW-1:0]        band0_freq,
    input  logic [ctp_pkg::FW-1:0]        band1_freq,
    input  logic [ctp_pkg::FW-1:0]        band2_freq,
    input  logic [ctp_pkg::FW-1:0]        band3_freq,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ctp_pkg::SLOT_W-1:0]    slot_index,
    output logic [ctp_pkg::FW-1:0]        slot_freq,
    output logic [ctp_pkg::QW-1:0]        slot_gain,
    output logic                          last_slot,
    input  logic                          cfg_we,
    input  logic [ctp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ctp_pkg::FW-1:0]        cfg_data
);
    import ctp_pkg::*;

    ctp_cmd_t cmd;
    ctp_sts_t sts;
    logic busy, in_fire, out_free;

    assign in_stall = busy;
    assign in_fire  = in_valid && !busy;
    assign out_free = !out_valid || !out_stall;

    ctp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    ctp_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .global_energy (global_energy),
        .band0_energy  (band0_energy),
        .band1_energy  (band1_energy),
        .band2_energy  (band2_energy),
        .band3_energy  (band3_energy),
        .band0_freq    (band0_freq),
        .band1_freq    (band1_freq),
        .band2_freq    (band2_freq),
        .band3_freq    (band3_freq),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .slot_index    (slot_index),
        .slot_freq     (slot_freq),
        .slot_gain     (slot_gain),
        .last_slot     (last_slot)
    );
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for combination_tone_planner: directed and random tone plans.
// Depends on ctp_pkg and the planner RTL; predicts every slot and compares in order.
`timescale 1ns / 100ps

module tb;
    import ctp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [SLOT_W-1:0] idx;
        logic [FW-1:0]     freq;
        logic [QW-1:0]     gain;
        logic              last;
    } slot_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [QW-1:0]     global_energy;
    logic [QW-1:0]     band_e [4];
    logic [FW-1:0]     band_f [4];
    logic              out_valid;
    logic              out_stall;
    logic [SLOT_W-1:0] slot_index;
    logic [FW-1:0]     slot_freq;
    logic [QW-1:0]     slot_gain;
    logic              last_slot;
    logic              cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FW-1:0]     cfg_data;

    // predictor state
    logic [QW-1:0] thr_q;
    logic [QW-1:0] mix_q;
    logic [FW-1:0] upper_lim;
    logic [FW-1:0] freq_store [TONE_SLOTS];
    slot_t         plan_q [$];

    int  mismatches;
    bit  idle_on;

    combination_tone_planner i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .global_energy(global_energy),
        .band0_energy(band_e[0]), .band1_energy(band_e[1]),
        .band2_energy(band_e[2]), .band3_energy(band_e[3]),
        .band0_freq(band_f[0]), .band1_freq(band_f[1]),
        .band2_freq(band_f[2]), .band3_freq(band_f[3]),
        .out_valid(out_valid), .out_stall(out_stall),
        .slot_index(slot_index), .slot_freq(slot_freq), .slot_gain(slot_gain),
        .last_slot(last_slot), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [QW-1:0] sat_q(input logic [QW-1:0] v);
        return (v > Q_ONE) ? Q_ONE : v;
    endfunction

    // Work out the slots one input item yields and update the store.
    task automatic plan_tones(input logic [QW-1:0] ge, input logic [QW-1:0] e_in [4],
                              input logic [FW-1:0] f_in [4]);
        logic [QW-1:0] g, e [4], te [3];
        logic [FW-1:0] tf [3];
        logic [31:0]   gain [TONE_SLOTS];
        logic [63:0]   scale, num, p, gs, gd;
        logic [20:0]   sumf, difff;
        int            rank, filled;
        slot_t         s;
        g = sat_q(ge);
        filled = 0;
        for (int i = 0; i < TONE_SLOTS; i++) gain[i] = 0;
        for (int i = 0; i < 4; i++) e[i] = sat_q(e_in[i]);
        if (g >= thr_q)
        begin
            if (thr_q >= Q_ONE) scale = Q_ONE;
            else
            begin
                num = 64'(g - thr_q) << 15;
                scale = num / 64'(Q_ONE - thr_q);
                if (scale > Q_ONE) scale = Q_ONE;
            end
            for (int i = 0; i < 4; i++)
            begin
                rank = 0;
                for (int j = 0; j < 4; j++)
                    if (e[j] > e[i] || (e[j] == e[i] && j < i)) rank++;
                if (rank < 3)
                begin
                    te[rank] = e[i];
                    tf[rank] = f_in[i];
                end
            end
            for (int i = 0; i < 3; i++)
                for (int j = i + 1; j < 3; j++)
                begin
                    p = (64'(te[i]) * te[j]) >> 15;
                    gs = (p * scale) >> 15;
                    gs = (gs * mix_q) >> 15;
                    gd = (gs * DIFF_WEIGHT) >> 15;
                    sumf = 21'(tf[i]) + 21'(tf[j]);
                    difff = (tf[i] > tf[j]) ? 21'(tf[i] - tf[j]) : 21'(tf[j] - tf[i]);
                    if (filled < TONE_SLOTS && sumf > MIN_FREQ && sumf < upper_lim)
                    begin
                        freq_store[filled] = sumf[FW-1:0];
                        gain[filled] = gs[31:0];
                        filled++;
                    end
                    if (filled < TONE_SLOTS && difff > MIN_FREQ && difff < upper_lim)
                    begin
                        freq_store[filled] = difff[FW-1:0];
                        gain[filled] = gd[31:0];
                        filled++;
                    end
                end
        end
        for (int k = 0; k < TONE_SLOTS; k++)
        begin
            s.idx = SLOT_W'(k);
            s.freq = freq_store[k];
            s.gain = gain[k][QW-1:0];
            s.last = (k == TONE_SLOTS - 1);
            plan_q.push_back(s);
        end
    endtask

    task automatic random_gap();
        if (idle_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 9)) @(negedge clk);
    endtask

    task automatic send_item(input logic [QW-1:0] ge, input logic [QW-1:0] e [4],
                             input logic [FW-1:0] f [4]);
        random_gap();
        // hold valid low between the previous item and this one
        @(negedge clk);
        in_valid <= 1'b1;
        global_energy <= ge;
        for (int i = 0; i < 4; i++)
        begin
            band_e[i] <= e[i];
            band_f[i] <= f[i];
        end
        plan_tones(ge, e, f);
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (plan_q.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FW-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_THRESHOLD) thr_q = sat_q(v[QW-1:0]);
        else if (idx == REG_MIX) mix_q = sat_q(v[QW-1:0]);
        else if (idx == REG_UPPER) upper_lim = v;
    endtask

    // Random energies lean on the Q1.15 range, with some over-range and ties.
    function automatic logic [QW-1:0] rand_energy();
        case ($urandom_range(0, 9))
            0: return Q_ONE;
            1: return QW'($urandom);
            2: return 16'd0;
            default: return QW'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [FW-1:0] rand_freq();
        case ($urandom_range(0, 7))
            0: return FW'($urandom);
            1: return FW'($urandom_range(0, 400));
            default: return FW'($urandom_range(300, 160000));
        endcase
    endfunction

    task automatic send_random(input int n);
        logic [QW-1:0] e [4];
        logic [FW-1:0] f [4];
        logic [QW-1:0] ge;
        for (int k = 0; k < n; k++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                e[i] = rand_energy();
                f[i] = rand_freq();
            end
            if ($urandom_range(0, 5) == 0) e[$urandom_range(0, 3)] = e[0];
            ge = rand_energy();
            send_item(ge, e, f);
        end
    endtask

    task automatic test_directed();
        logic [QW-1:0] e [4];
        logic [FW-1:0] f [4];
        e = '{16'd32768, 16'd16384, 16'd8192, 16'd0};
        f = '{20'd16000, 20'd8000, 20'd4000, 20'd2000};
        send_item(16'd32768, e, f);
        // ties go to the lower band
        e = '{16'd1000, 16'd1000, 16'd1000, 16'd1000};
        send_item(16'd20000, e, f);
        // over-range energies clamp to one
        e = '{16'hFFFF, 16'h8001, 16'd5, 16'hC000};
        f = '{20'hFFFFF, 20'd0, 20'd320, 20'd321};
        send_item(16'hFFFF, e, f);
        // difference at exactly 20 Hz and tiny tones are dropped
        f = '{20'd1000, 20'd680, 20'd1320, 20'd10};
        e = '{16'd30000, 16'd20000, 16'd10000, 16'd0};
        send_item(16'd0, e, f);
        // sum overflow past 20 bits
        f = '{20'hFFFFF, 20'hFFFF0, 20'h80000, 20'd1};
        send_item(16'd12345, e, f);
        e = '{16'd0, 16'd0, 16'd0, 16'd0};
        f = '{20'd0, 20'd0, 20'd0, 20'd0};
        send_item(16'd0, e, f);
    endtask

    task automatic test_threshold_and_limits();
        logic [QW-1:0] e [4];
        logic [FW-1:0] f [4];
        e = '{16'd32768, 16'd30000, 16'd20000, 16'd100};
        f = '{20'd64000, 20'd32000, 20'd9000, 20'd700};
        write_reg(REG_THRESHOLD, 20'd16384);
        send_item(16'd16383, e, f);       // silenced: gains zero, store kept
        send_item(16'd16384, e, f);
        send_item(16'd32768, e, f);
        write_reg(REG_THRESHOLD, 20'hFFFFF); // clamps to one
        send_item(16'd32768, e, f);
        send_item(16'd32767, e, f);
        write_reg(REG_MIX, 20'd0);
        send_item(16'd32768, e, f);
        write_reg(REG_MIX, 20'hFFFFF);
        write_reg(REG_UPPER, 20'd0);
        send_item(16'd32768, e, f);
        write_reg(REG_UPPER, 20'hFFFFF);
        write_reg(REG_UNUSED, 20'h12345); // out-of-range index ignored
        send_item(16'd32768, e, f);
        write_reg(REG_THRESHOLD, 20'd0);
        write_reg(REG_UPPER, UPPER_RESET);
        write_reg(REG_MIX, 20'd16384);
        send_item(16'd100, e, f);
    endtask

    task automatic test_random();
        write_reg(REG_MIX, 20'd32768);
        send_random(120);
        write_reg(REG_THRESHOLD, 20'($urandom_range(1, 32767)));
        write_reg(REG_MIX, 20'($urandom_range(0, 65535)));
        write_reg(REG_UPPER, 20'($urandom_range(1000, 400000)));
        send_random(120);
        write_reg(REG_THRESHOLD, 20'd0);
        write_reg(REG_MIX, 20'd32768);
        write_reg(REG_UPPER, 20'hFFFFF);
        send_random(80);
        idle_on = 1'b0;
        send_random(80);
    endtask

    // Check every slot against the oldest planned one.
    always @(posedge clk)
    begin
        slot_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (plan_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected slot %0d", slot_index);
            end
            else
            begin
                want = plan_q.pop_front();
                if (want.idx !== slot_index || want.freq !== slot_freq ||
                    want.gain !== slot_gain || want.last !== last_slot)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d f %0d g %0d l %0b, got %0d %0d %0d %0b",
                                 want.idx, want.freq, want.gain, want.last,
                                 slot_index, slot_freq, slot_gain, last_slot);
                end
            end
        end
    end

    // Stall the output in random bursts while idling is on.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        global_energy = '0;
        for (int i = 0; i < 4; i++)
        begin
            band_e[i] = '0;
            band_f[i] = '0;
        end
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        idle_on = 1'b1;
        thr_q = '0;
        mix_q = Q_ONE;
        upper_lim = UPPER_RESET;
        for (int i = 0; i < TONE_SLOTS; i++) freq_store[i] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_threshold_and_limits();
        test_random();
        drain();
        if (mismatches == 0 && plan_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== combination_tone_planner.f =====
src/ctp_pkg.sv
src/ctp_ctrl.sv
src/ctp_dp.sv
src/combination_tone_planner.sv
tb/tb.sv
